FILE: sv/tci_pkg.sv
// Shared constants, codes and helpers for the text command interpreter.
// No dependencies; imported by text_command_interpreter_core.
package tci_pkg;

  // Receive text buffer depth; one slot is reserved for the terminator.
  localparam int unsigned BufferSize = 32;
  localparam int unsigned CntW       = $clog2(BufferSize);

  localparam int unsigned ScaleW = 10;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned CmpW   = 16;
  localparam int unsigned ProdW  = DutyW + ScaleW;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(10);
  localparam logic [DutyW-1:0]  DutyReset  = DutyW'(50);
  localparam logic [DutyW-1:0]  DutyMax    = DutyW'(100);
  localparam logic [DutyW-1:0]  DutySat    = DutyW'(101);

  localparam logic [7:0] ChEnd     = 8'h21;  // '!'
  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChNine    = 8'h39;  // '9'
  localparam logic [7:0] ChNul     = 8'h00;

  // Candidate bit positions
  localparam int unsigned CandOn     = 0;
  localparam int unsigned CandOff    = 1;
  localparam int unsigned CandStatus = 2;
  localparam int unsigned CandPwm    = 3;

  typedef enum logic [2:0] {
    RESP_NONE   = 3'd0,
    RESP_ON     = 3'd1,
    RESP_OFF    = 3'd2,
    RESP_STATUS = 3'd3,
    RESP_PWM    = 3'd4,
    RESP_ERROR  = 3'd5
  } resp_e;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Expected characters of each command word by position; zero past the end.
  function automatic logic [7:0] word_on_char(input logic [CntW-1:0] pos);
    unique case (pos)
      CntW'(0): return 8'h4f;  // O
      CntW'(1): return 8'h4e;  // N
      default:  return ChNul;
    endcase
  endfunction

  function automatic logic [7:0] word_off_char(input logic [CntW-1:0] pos);
    unique case (pos)
      CntW'(0): return 8'h4f;  // O
      CntW'(1): return 8'h46;  // F
      CntW'(2): return 8'h46;  // F
      default:  return ChNul;
    endcase
  endfunction

  function automatic logic [7:0] word_status_char(input logic [CntW-1:0] pos);
    unique case (pos)
      CntW'(0): return 8'h53;  // S
      CntW'(1): return 8'h54;  // T
      CntW'(2): return 8'h41;  // A
      CntW'(3): return 8'h54;  // T
      CntW'(4): return 8'h55;  // U
      CntW'(5): return 8'h53;  // S
      default:  return ChNul;
    endcase
  endfunction

  function automatic logic [7:0] word_pwm_char(input logic [CntW-1:0] pos);
    unique case (pos)
      CntW'(0): return 8'h50;  // P
      CntW'(1): return 8'h57;  // W
      CntW'(2): return 8'h4d;  // M
      CntW'(3): return 8'h3a;  // :
      default:  return ChNul;
    endcase
  endfunction

endpackage

FILE: sv/text_command_interpreter_core.sv
// Text command interpreter: byte-wise ON/OFF/STATUS/PWM:n! recognizer.
// Accepted bytes pass the input register, then the result register;
// throughput one byte per cycle while the output is not stalled, set by
// the single parse pass between the two registers. Reset is asynchronous,
// active low: LED off, duty 50, scale 10, parse cleared. Depends on tci_pkg.
module text_command_interpreter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tci_pkg::ScaleW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  response_o,
  output logic                        led_on_o,
  output logic [tci_pkg::DutyW-1:0]   duty_percent_o,
  output logic [tci_pkg::CmpW-1:0]    compare_value_o
);
  import tci_pkg::*;

  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              advance;

  logic [ScaleW-1:0] scale_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              led_q, led_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [3:0]        cand_q, cand_d;
  logic [DutyW-1:0]  digit_q, digit_d;
  logic              dseen_q, dseen_d;
  logic              pseen_q, pseen_d;
  logic              tbad_q, tbad_d;
  logic              ended_q, ended_d;
  resp_e             resp_d;

  logic              out_valid_q;
  resp_e             resp_q;
  logic              led_out_q;
  logic [DutyW-1:0]  duty_out_q;
  logic [CmpW-1:0]   cmp_q, cmp_d;

  logic [7:0]        up;
  logic [10:0]       acc;
  logic [ProdW-1:0]  prod;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign up  = upcase(s1_byte_q);
  assign acc = 11'(digit_q) * 11'd10 + 11'(s1_byte_q - ChZero);

  always_comb begin
    cnt_d   = cnt_q;
    led_d   = led_q;
    duty_d  = duty_q;
    cand_d  = cand_q;
    digit_d = digit_q;
    dseen_d = dseen_q;
    pseen_d = pseen_q;
    tbad_d  = tbad_q;
    ended_d = ended_q;
    resp_d  = RESP_NONE;
    if (s1_byte_q == ChEnd) begin
      priority if (cand_q[CandOn] && cnt_q == CntW'(2)) begin
        led_d  = 1'b1;
        resp_d = RESP_ON;
      end else if (cand_q[CandOff] && cnt_q == CntW'(3)) begin
        led_d  = 1'b0;
        resp_d = RESP_OFF;
      end else if (cand_q[CandStatus] && cnt_q == CntW'(6)) begin
        resp_d = RESP_STATUS;
      end else if (cand_q[CandPwm] && cnt_q >= CntW'(4) && dseen_q && !tbad_q
                   && digit_q <= DutyMax) begin
        duty_d = digit_q;
        resp_d = RESP_PWM;
      end else begin
        resp_d = RESP_ERROR;
      end
      // clear parse for the next command
      cnt_d   = '0;
      cand_d  = '1;
      digit_d = '0;
      dseen_d = 1'b0;
      pseen_d = 1'b0;
      tbad_d  = 1'b0;
      ended_d = 1'b0;
    end else if (!ended_q && cnt_q < CntW'(BufferSize - 1)) begin
      if (s1_byte_q == ChNul) begin
        ended_d = 1'b1;
      end else begin
        if (up != word_on_char(cnt_q))     cand_d[CandOn]     = 1'b0;
        if (up != word_off_char(cnt_q))    cand_d[CandOff]    = 1'b0;
        if (up != word_status_char(cnt_q)) cand_d[CandStatus] = 1'b0;
        if (cnt_q < CntW'(4)) begin
          if (up != word_pwm_char(cnt_q)) cand_d[CandPwm] = 1'b0;
        end else if (!tbad_q) begin
          priority if (pseen_q) begin
            tbad_d = 1'b1;
          end else if (s1_byte_q >= ChZero && s1_byte_q <= ChNine) begin
            digit_d = (acc > 11'(DutyMax)) ? DutySat : acc[DutyW-1:0];
            dseen_d = 1'b1;
          end else if (s1_byte_q == ChPercent) begin
            pseen_d = 1'b1;
          end else begin
            tbad_d = 1'b1;
          end
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  assign prod  = ProdW'(duty_d) * ProdW'(scale_q);
  assign cmp_d = !led_d ? '0 :
                 (prod > ProdW'({CmpW{1'b1}})) ? '1 : prod[CmpW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      led_q   <= 1'b0;
      duty_q  <= DutyReset;
      cand_q  <= '1;
      digit_q <= '0;
      dseen_q <= 1'b0;
      pseen_q <= 1'b0;
      tbad_q  <= 1'b0;
      ended_q <= 1'b0;
    end else if (advance) begin
      cnt_q   <= cnt_d;
      led_q   <= led_d;
      duty_q  <= duty_d;
      cand_q  <= cand_d;
      digit_q <= digit_d;
      dseen_q <= dseen_d;
      pseen_q <= pseen_d;
      tbad_q  <= tbad_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      resp_q     <= resp_d;
      led_out_q  <= led_d;
      duty_out_q <= duty_d;
      cmp_q      <= cmp_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign response_o      = resp_q;
  assign led_on_o        = led_out_q;
  assign duty_percent_o  = duty_out_q;
  assign compare_value_o = cmp_q;

  // Result register reflects the state committed with it
  a_led_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (led_out_q == led_q && duty_out_q == duty_q))
    else $error("result register out of step with stored state");

  a_cmp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !led_out_q) |-> (cmp_q == '0))
    else $error("compare value nonzero with LED off");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DutyMax)
    else $error("stored duty above 100");

  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_byte_q == ChEnd) |=> (cnt_q == '0 && cand_q == '1))
    else $error("parse not cleared after terminator");

endmodule

FILE: verif/text_command_interpreter_checker.sv
// Checker for the text command interpreter: tracks the command parse byte by byte,
// queues the expected status for every accepted request and compares replies.
// Depends on tci_pkg for widths, character codes and response codes.
`timescale 1ns / 100ps

module text_command_interpreter_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tci_pkg::ScaleW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [2:0]                  response_i,
  input  logic                        led_on_i,
  input  logic [tci_pkg::DutyW-1:0]   duty_percent_i,
  input  logic [tci_pkg::CmpW-1:0]    compare_value_i,
  output int                          pending_o,
  output int                          fail_count_o,
  output int                          checked_o
);
  import tci_pkg::*;

  localparam int unsigned KeepMax = BufferSize - 1;

  localparam logic [47:0] WordOn     = "ON";
  localparam logic [47:0] WordOff    = "OFF";
  localparam logic [47:0] WordStatus = "STATUS";
  localparam logic [47:0] WordPwm    = "PWM:";

  typedef struct packed {
    logic [2:0]       response;
    logic             led;
    logic [DutyW-1:0] duty;
    logic [CmpW-1:0]  cmp;
  } reply_t;

  reply_t reply_q[$];

  logic [ScaleW-1:0] scale_q;
  logic              led_q;
  logic [DutyW-1:0]  duty_q;
  logic [CntW-1:0]   kept_cnt;
  logic [3:0]        alive;
  logic [DutyW-1:0]  arg_val;
  logic              arg_digit;
  logic              arg_pct;
  logic              arg_bad;
  logic              text_done;
  int                fails;
  int                checked;

  function automatic logic [7:0] caps_char(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // w holds the word right-aligned, first character in the highest used byte.
  function automatic logic word_ok(input logic [47:0] w, input int len, input int pos,
                                   input logic [7:0] c);
    if (pos >= len) begin
      return 1'b0;
    end
    return caps_char(c) == w[8*(len-1-pos) +: 8];
  endfunction

  function automatic void clear_parse();
    kept_cnt  = '0;
    alive     = 4'hf;
    arg_val   = '0;
    arg_digit = 1'b0;
    arg_pct   = 1'b0;
    arg_bad   = 1'b0;
    text_done = 1'b0;
  endfunction

  function automatic reply_t interpret_byte(input logic [7:0] c);
    reply_t      r;
    logic [16:0] prod;
    int          v;
    r.response = RESP_NONE;
    if (c == ChEnd) begin
      if (alive[CandOn] && kept_cnt == 2) begin
        led_q = 1'b1;
        r.response = RESP_ON;
      end else if (alive[CandOff] && kept_cnt == 3) begin
        led_q = 1'b0;
        r.response = RESP_OFF;
      end else if (alive[CandStatus] && kept_cnt == 6) begin
        r.response = RESP_STATUS;
      end else if (alive[CandPwm] && kept_cnt >= 4 && arg_digit && !arg_bad &&
                   arg_val <= DutyMax) begin
        duty_q = arg_val;
        r.response = RESP_PWM;
      end else begin
        r.response = RESP_ERROR;
      end
      clear_parse();
    end else if (!text_done && kept_cnt < KeepMax) begin
      if (c == ChNul) begin
        text_done = 1'b1;
      end else begin
        if (!word_ok(WordOn, 2, kept_cnt, c)) alive[CandOn] = 1'b0;
        if (!word_ok(WordOff, 3, kept_cnt, c)) alive[CandOff] = 1'b0;
        if (!word_ok(WordStatus, 6, kept_cnt, c)) alive[CandStatus] = 1'b0;
        if (kept_cnt < 4) begin
          if (!word_ok(WordPwm, 4, kept_cnt, c)) alive[CandPwm] = 1'b0;
        end else if (!arg_bad) begin
          if (arg_pct) begin
            arg_bad = 1'b1;
          end else if (c >= ChZero && c <= ChNine) begin
            // saturate the accumulator just above the legal range
            v = int'(arg_val) * 10 + int'(c - ChZero);
            arg_val = (v > int'(DutyMax)) ? DutySat : DutyW'(v);
            arg_digit = 1'b1;
          end else if (c == ChPercent) begin
            arg_pct = 1'b1;
          end else begin
            arg_bad = 1'b1;
          end
        end
        kept_cnt++;
      end
    end
    prod = 17'(duty_q) * 17'(scale_q);
    r.led  = led_q;
    r.duty = duty_q;
    if (!led_q) begin
      r.cmp = '0;
    end else if (prod > 17'hffff) begin
      r.cmp = 16'hffff;
    end else begin
      r.cmp = prod[15:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reply_t want;
    if (!rst_ni) begin
      clear_parse();
      scale_q = ScaleReset;
      led_q   = 1'b0;
      duty_q  = DutyReset;
      reply_q.delete();
      fails   = 0;
      checked = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        scale_q = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        reply_q.push_back(interpret_byte(rx_byte_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual response %0d duty %0d",
                   $time, response_i, duty_percent_i);
          fails++;
        end else begin
          want = reply_q.pop_front();
          check_field("response", want.response, response_i);
          check_field("led_on", want.led, led_on_i);
          check_field("duty_percent", want.duty, duty_percent_i);
          check_field("compare_value", want.cmp, compare_value_i);
          checked++;
        end
      end
      pending_o    <= reply_q.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

FILE: verif/text_command_interpreter_core_tb.sv
// Top of the text command interpreter testbench: clock, reset, command stimulus,
// scale register writes and the verdict. Depends on tci_pkg, the core and the checker.
`timescale 1ns / 100ps

module text_command_interpreter_core_tb;
  import tci_pkg::*;

  localparam int unsigned RandBytes  = 1600;
  localparam int unsigned CycleLimit = 400000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ScaleW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        response;
  logic              led_on;
  logic [DutyW-1:0]  duty_percent;
  logic [CmpW-1:0]   compare_value;

  int pending;
  int fail_count;
  int checked_count;

  int cycles;
  int bytes_sent;
  int cmds_sent;
  int scale_writes;
  int burst_left;
  int stall_mode;
  int mode_left;

  logic [7:0] cmd_buf[$];

  string plain_cmds[$] = '{"ON!", "PWM:100%!", "sTaTuS!", "pwm:0!", "Pwm:037!", "PWM:101!",
                           "PWM:99999!", "PWM:!", "PWM:%5!", "PWM:5%%!", "PWM:7%x!",
                           "PWM:4x!", "!", "QZ!", "ONN!", "OF!", "STATU!", "PWM5!",
                           "off!"};

  text_command_interpreter_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .response_o      (response),
    .led_on_o        (led_on),
    .duty_percent_o  (duty_percent),
    .compare_value_o (compare_value)
  );

  text_command_interpreter_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .response_i      (response),
    .led_on_i        (led_on),
    .duty_percent_i  (duty_percent),
    .compare_value_i (compare_value),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .checked_o       (checked_count)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d replies outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: switch between randomly chosen stall patterns.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 12 == 0);
    endcase
  end

  // Hold each request until accepted; open a new burst after a random gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
        rx_byte  = 8'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_scale(input logic [ScaleW-1:0] v);
    drain();
    repeat (3) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    scale_writes++;
  endtask

  task automatic put_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1) == 1) begin
        c = c + 8'h20;
      end
      cmd_buf.push_back(c);
    end
  endtask

  task automatic send_cmd();
    foreach (cmd_buf[i]) begin
      send_byte(cmd_buf[i]);
    end
    cmd_buf.delete();
    cmds_sent++;
  endtask

  // Mostly well-formed commands with random case and arguments; the rest
  // is corrupted commands and raw noise.
  task automatic build_random_cmd();
    int kind;
    int val;
    int pos;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: put_text("ON", 1);
      2, 3: put_text("OFF", 1);
      4:    put_text("STATUS", 1);
      8: begin
        repeat ($urandom_range(0, 12)) cmd_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        put_text("PWM:", 1);
        val = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 9999) : $urandom_range(0, 100);
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) cmd_buf.push_back(ChZero);
        end
        if ($urandom_range(0, 9) != 0) begin
          put_text($sformatf("%0d", val), 0);
        end
        if ($urandom_range(0, 1) == 1) cmd_buf.push_back(ChPercent);
      end
    endcase
    if (kind != 8 && $urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, cmd_buf.size());
      case ($urandom_range(0, 4))
        0: if (pos < cmd_buf.size()) cmd_buf[pos] = 8'($urandom_range(0, 255));
        1: cmd_buf.insert(pos, ChNul);
        2: if (pos < cmd_buf.size()) cmd_buf.delete(pos);
        3: repeat ($urandom_range(1, 4)) cmd_buf.push_back(8'($urandom_range(32, 126)));
        default: begin
          // push past the kept text length
          repeat ($urandom_range(26, 40)) cmd_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
        end
      endcase
    end
    cmd_buf.push_back(ChEnd);
  endtask

  initial begin
    logic [ScaleW-1:0] phase_scale[4];
    int target;
    bit paused;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = ScaleReset;
    in_valid   = 1'b0;
    rx_byte    = '0;
    burst_left = 0;
    paused     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed commands run with the reset scale.
    foreach (plain_cmds[i]) begin
      put_text(plain_cmds[i], 0);
      send_cmd();
    end
    put_text("ON", 0);
    cmd_buf.push_back(ChNul);
    put_text("xyz!", 0);
    send_cmd();
    cmd_buf.push_back(ChNul);
    cmd_buf.push_back(ChEnd);
    send_cmd();
    // Overlong: the digits past the kept length are dropped, a late zero too.
    put_text("PWM:", 0);
    repeat (26) cmd_buf.push_back(ChZero);
    put_text("42!", 0);
    send_cmd();
    put_text("PWM:", 0);
    repeat (27) cmd_buf.push_back(ChZero);
    cmd_buf.push_back(ChNul);
    put_text("9!", 0);
    send_cmd();
    cmd_buf = '{8'hff, 8'h80, 8'h7f, ChEnd};
    send_cmd();
    put_text("On!", 0);
    send_cmd();

    phase_scale = '{10'd655, 10'd1, 10'd511, 10'($urandom_range(2, 654))};
    foreach (phase_scale[ph]) begin
      write_scale(phase_scale[ph]);
      target = bytes_sent + RandBytes / 4;
      while (bytes_sent < target) begin
        if (ph == 1 && !paused && bytes_sent >= target - RandBytes / 8) begin
          drain();
          paused = 1'b1;
        end
        build_random_cmd();
        send_cmd();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Sent %0d bytes in %0d commands over %0d scale settings plus the reset value",
             bytes_sent, cmds_sent, scale_writes);
    $display("Checked %0d replies, %0d failures", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tci_pkg.sv
sv/text_command_interpreter_core.sv
verif/text_command_interpreter_checker.sv
verif/text_command_interpreter_core_tb.sv
